### design/tms_pkg.sv
// Shared types, register map and note tables for the tone melody sequencer.
package tms_pkg;

  typedef enum logic [0:0] {
    OP_TICK   = 1'b0,
    OP_SELECT = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic signed [31:0] now;
    logic               enabled;
    logic [1:0]         track_sel;
  } in_item_t;

  typedef struct packed {
    logic       tone_write;
    logic [9:0] tone_hz;
    logic       playing;
  } out_item_t;

  localparam int unsigned PADDR_W = 3;

  localparam logic [0:0] REG_SOUND_ON  = 1'b0;
  localparam logic [0:0] REG_GAP_TICKS = 1'b1;

  localparam logic [1:0] TRACK_NONE    = 2'd0;
  localparam logic [1:0] TRACK_FANFARE = 2'd1;

  localparam logic [3:0] FANFARE_LEN = 4'd6;
  localparam logic [3:0] THEME_LEN   = 4'd11;

  localparam logic [6:0] GAP_RESET = 7'd40;

  function automatic logic [9:0] note_pitch(input logic fanfare, input logic [3:0] idx);
    logic [9:0] hz;
    hz = '0;
    if (fanfare) begin
      case (idx)
        4'd0:    hz = 10'd392;
        4'd1:    hz = 10'd494;
        4'd2:    hz = 10'd587;
        4'd3:    hz = 10'd784;
        4'd4:    hz = 10'd698;
        4'd5:    hz = 10'd659;
        default: hz = '0;
      endcase
    end else begin
      case (idx)
        4'd0:    hz = 10'd262;
        4'd1:    hz = 10'd330;
        4'd2:    hz = 10'd392;
        4'd3:    hz = 10'd440;
        4'd4:    hz = 10'd349;
        4'd5:    hz = 10'd294;
        4'd6:    hz = 10'd262;
        4'd7:    hz = 10'd330;
        4'd8:    hz = 10'd392;
        4'd9:    hz = 10'd523;
        4'd10:   hz = 10'd392;
        default: hz = '0;
      endcase
    end
    return hz;
  endfunction

  function automatic logic [8:0] note_dur(input logic fanfare, input logic [3:0] idx);
    logic [8:0] d;
    d = '0;
    if (fanfare) begin
      d = 9'd250;
    end else begin
      case (idx)
        4'd0, 4'd1, 4'd3, 4'd4, 4'd6: d = 9'd150;
        4'd2, 4'd5, 4'd7, 4'd9:       d = 9'd200;
        4'd8:                         d = 9'd250;
        4'd10:                        d = 9'd300;
        default:                      d = '0;
      endcase
    end
    return d;
  endfunction

endpackage

### design/tone_melody_sequencer.sv
// Tone melody sequencer: one request in, one speaker result out, per cycle while results are taken.
//
// Input requests (in_valid/in_ready, in_data) are either a tick carrying the
// current millisecond count or a track select. Each accepted request yields
// exactly one result on out_valid/out_ready, out_data: whether a speaker
// command was issued, its pitch (0 = off) and whether a track is selected.
//
// The result is registered: the request is evaluated against the sequencer state
// in the accept cycle and the result lands in the output register, while the
// state registers update at the same edge. Throughput is one request per
// cycle while results are taken, set by the combinational state update (a
// 32-bit time subtract, signed compare and the next-event add).
//
// When the receiver stalls, the output register holds its result and
// in_ready drops until it is taken; a new request is accepted in the same
// cycle the held result leaves. Reset (rst_n low, synchronous) clears the
// track, note position and timing state, sets sound_on to 1 and gap_ticks
// to 40, and empties the output register. Config is via the APB port:
// sound_on at address 0, gap_ticks at address 4.
module tone_melody_sequencer
  import tms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic        sound_on_r;
  logic [6:0]  gap_ticks_r;
  logic [1:0]  track_r, track_nxt;
  logic [3:0]  note_index_r, note_index_nxt;
  logic        resting_r, resting_nxt;
  logic [31:0] next_time_r, next_time_nxt;
  logic        sounding_r, sounding_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_fire, cfg_wr;
  logic [31:0] now_u, diff;
  logic        now_lt, go, fanfare;
  logic [3:0]  len, idx, idx_inc;
  logic [9:0]  pitch;
  logic [8:0]  dur;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign prdata = (paddr[2] == REG_GAP_TICKS) ? {25'd0, gap_ticks_r} : {31'd0, sound_on_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_on_r  <= 1'b1;
      gap_ticks_r <= GAP_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SOUND_ON) begin
        sound_on_r <= pwdata[0];
      end else begin
        gap_ticks_r <= pwdata[6:0];
      end
    end
  end

  // time compare: a wrapped-negative difference snaps the event time to now
  assign now_u   = in_data.now;
  assign diff    = now_u - next_time_r;
  assign now_lt  = $signed(now_u) < $signed(next_time_r);
  assign go      = diff[31] || !now_lt;
  assign fanfare = (track_r == TRACK_FANFARE);
  assign len     = fanfare ? FANFARE_LEN : THEME_LEN;
  assign idx     = (note_index_r >= len) ? 4'd0 : note_index_r;
  assign idx_inc = idx + 4'd1;
  assign pitch   = note_pitch(fanfare, idx);
  assign dur     = note_dur(fanfare, idx);

  always_comb begin
    track_nxt      = track_r;
    note_index_nxt = note_index_r;
    resting_nxt    = resting_r;
    next_time_nxt  = next_time_r;
    sounding_nxt   = sounding_r;
    out_data_nxt   = '0;

    if (in_data.opcode == OP_SELECT) begin
      out_data_nxt.tone_write = sounding_r;
      sounding_nxt   = 1'b0;
      track_nxt      = in_data.track_sel;
      note_index_nxt = '0;
      resting_nxt    = 1'b0;
      next_time_nxt  = now_u;
    end else if (!in_data.enabled || !sound_on_r || track_r == TRACK_NONE) begin
      out_data_nxt.tone_write = sounding_r;
      sounding_nxt = 1'b0;
    end else begin
      if (diff[31]) begin
        next_time_nxt = now_u;
      end
      if (go) begin
        note_index_nxt = idx;
        if (resting_r) begin
          out_data_nxt.tone_write = sounding_r;
          sounding_nxt   = 1'b0;
          next_time_nxt  = now_u + {25'd0, gap_ticks_r};
          resting_nxt    = 1'b0;
          note_index_nxt = idx_inc;
          if (idx_inc >= len) begin
            note_index_nxt = '0;
            if (fanfare) begin
              track_nxt = TRACK_NONE;
            end
          end
        end else begin
          out_data_nxt.tone_write = 1'b1;
          out_data_nxt.tone_hz    = pitch;
          sounding_nxt  = 1'b1;
          next_time_nxt = now_u + {23'd0, dur} - {25'd0, gap_ticks_r};
          resting_nxt   = 1'b1;
        end
      end
    end
    out_data_nxt.playing = (track_nxt != TRACK_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r      <= TRACK_NONE;
      note_index_r <= '0;
      resting_r    <= 1'b0;
      next_time_r  <= '0;
      sounding_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        track_r      <= track_nxt;
        note_index_r <= note_index_nxt;
        resting_r    <= resting_nxt;
        next_time_r  <= next_time_nxt;
        sounding_r   <= sounding_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // note position never leaves the longer table
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    note_index_r < THEME_LEN)
    else $error("note index out of range");

  a_playing_track: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_data_r.playing == (track_r != TRACK_NONE))
    else $error("playing flag disagrees with track");

  a_hz_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.tone_write |-> out_data_r.tone_hz == '0)
    else $error("pitch without speaker command");

  a_select_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.opcode == OP_SELECT |=> note_index_r == '0 && !resting_r && !sounding_r)
    else $error("select did not restart track");

endmodule

### tb/sv/melody_checker.sv
`timescale 1ns / 1ps
// Result checker for the tone melody sequencer: tracks note state, predicts, compares.
module melody_checker
  import tms_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending,
  output int                 notes_heard
);

  // index 0 is the rightmost entry
  localparam logic [5:0][9:0] FAN_PITCH = {10'd659, 10'd698, 10'd784, 10'd587, 10'd494,
                                           10'd392};
  localparam logic [8:0] FAN_DUR = 9'd250;
  localparam logic [10:0][9:0] LOOP_PITCH = {10'd392, 10'd523, 10'd392, 10'd330, 10'd262,
                                             10'd294, 10'd349, 10'd440, 10'd392, 10'd330,
                                             10'd262};
  localparam logic [10:0][8:0] LOOP_DUR = {9'd300, 9'd200, 9'd250, 9'd200, 9'd150, 9'd200,
                                           9'd150, 9'd150, 9'd200, 9'd150, 9'd150};

  logic        snd_on;
  logic [6:0]  gap;
  logic [1:0]  trk;
  logic [3:0]  idx;
  logic        rest;
  logic [31:0] evt;
  logic        sounding;
  out_item_t   tone_due [$];

  // speaker off command, only if something is actually sounding
  function automatic void stop_tone(inout out_item_t r);
    if (sounding) begin
      r.tone_write = 1'b1;
      r.tone_hz    = '0;
      sounding     = 1'b0;
    end
  endfunction

  function automatic out_item_t next_tone(input in_item_t req);
    out_item_t   r;
    logic        fan;
    logic [3:0]  len;
    logic [8:0]  dur;
    logic [31:0] t;
    logic [31:0] diff;
    r = '0;
    t = req.now;
    if (req.opcode == OP_SELECT) begin
      stop_tone(r);
      trk  = req.track_sel;
      idx  = '0;
      rest = 1'b0;
      evt  = t;
    end else if (!req.enabled || !snd_on || trk == TRACK_NONE) begin
      stop_tone(r);
    end else begin
      fan  = (trk == TRACK_FANFARE);
      len  = fan ? FANFARE_LEN : THEME_LEN;
      diff = t - evt;
      if (diff[31]) evt = t;
      // still waiting on the current event: nothing to do
      if ($signed(t) >= $signed(evt)) begin
        if (idx >= len) idx = '0;
        if (rest) begin
          stop_tone(r);
          evt  = t + 32'(gap);
          rest = 1'b0;
          idx  = idx + 4'd1;
          if (idx >= len) begin
            idx = '0;
            if (fan) begin
              trk = TRACK_NONE;
              stop_tone(r);
            end
          end
        end else begin
          dur          = fan ? FAN_DUR : LOOP_DUR[idx];
          r.tone_write = 1'b1;
          r.tone_hz    = fan ? FAN_PITCH[idx] : LOOP_PITCH[idx];
          sounding     = 1'b1;
          evt          = t + 32'(dur) - 32'(gap);
          rest         = 1'b1;
        end
      end
    end
    r.playing = (trk != TRACK_NONE);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      snd_on      = 1'b1;
      gap         = GAP_RESET;
      trk         = TRACK_NONE;
      idx         = '0;
      rest        = 1'b0;
      evt         = '0;
      sounding    = 1'b0;
      fail_count  = 0;
      notes_heard = 0;
      tone_due.delete();
    end else begin
      // results first, so a result never matches a request taken at the same edge
      if (out_valid && out_ready) begin
        if (tone_due.size() == 0) begin
          $display("%0t: result with no request pending: %p", $time, out_data);
          fail_count++;
        end else begin
          want = tone_due.pop_front();
          if (want.tone_write && want.tone_hz != 0) notes_heard++;
          if (out_data.tone_write !== want.tone_write) begin
            $display("%0t: tone_write expected %0d got %0d", $time, want.tone_write,
                     out_data.tone_write);
            fail_count++;
          end
          if (out_data.tone_hz !== want.tone_hz) begin
            $display("%0t: tone_hz expected %0d got %0d", $time, want.tone_hz,
                     out_data.tone_hz);
            fail_count++;
          end
          if (out_data.playing !== want.playing) begin
            $display("%0t: playing expected %0d got %0d", $time, want.playing,
                     out_data.playing);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) tone_due.push_back(next_tone(in_data));
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_SOUND_ON) begin
          snd_on = pwdata[0];
        end else if (paddr[PADDR_W-1:2] == REG_GAP_TICKS) begin
          gap = pwdata[6:0];
        end
      end
    end
    pending = tone_due.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the tone melody sequencer: clock, reset, stimulus and verdict.
module testbench;
  import tms_pkg::*;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  int          fail_count;
  int          pending;
  int          notes_heard;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  bit          calm      = 1'b0;
  int          n_sent    = 0;
  int          n_results = 0;
  logic [31:0] ms_now    = '0;

  tone_melody_sequencer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  melody_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending),
    .notes_heard(notes_heard)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= (calm || $urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) n_results <= n_results + 1;
  end

  function automatic in_item_t mk(input opcode_t op, input logic [31:0] t, input logic en,
                                  input logic [1:0] sel);
    in_item_t req;
    req.opcode    = op;
    req.now       = t;
    req.enabled   = en;
    req.track_sel = sel;
    return req;
  endfunction

  task automatic send_req(input in_item_t req);
    @(negedge clk);
    while (!calm && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic apb_write(input logic [0:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // wait for every result, then give the output register time to drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (n_results != n_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // select a track, then tick through it with mostly forward-moving time
  task automatic melody_run();
    int          n_ticks;
    int          j;
    logic [1:0]  sel;
    case ($urandom_range(9))
      0: ms_now = $urandom;
      1: ms_now = 32'h7FFF_FF00 + 32'($urandom_range(255));
      2: ms_now = 32'hFFFF_FF00 + 32'($urandom_range(255));
      default: ;
    endcase
    sel = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(1, 2));
    send_req(mk(OP_SELECT, ms_now, 1'($urandom_range(1)), sel));
    n_ticks = $urandom_range(40, 160);
    for (j = 0; j < n_ticks; j++) begin
      case ($urandom_range(49))
        0:       ms_now = ms_now - 32'($urandom_range(1, 400));
        1, 2:    ms_now = ms_now + 32'($urandom_range(200, 700));
        default: ms_now = ms_now + 32'($urandom_range(1, 40));
      endcase
      send_req(mk(OP_TICK, ms_now, $urandom_range(24) != 0, 2'($urandom)));
    end
  endtask

  task automatic noise_burst();
    int k;
    int n;
    n = $urandom_range(4, 16);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(1) == 1) ms_now = $urandom;
      else ms_now = ms_now + 32'($urandom_range(0, 300));
      send_req(mk(opcode_t'($urandom_range(1)), ms_now, 1'($urandom_range(1)),
                  2'($urandom)));
    end
  endtask

  initial begin
    int         p;
    int         start;
    logic       snd;
    logic [6:0] gp;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, no idling
    calm = 1'b1;
    send_req(mk(OP_TICK,   32'd0,    1'b1, 2'd2));  // no track yet
    send_req(mk(OP_SELECT, 32'd1000, 1'b0, 2'd1));
    send_req(mk(OP_TICK,   32'd1000, 1'b1, 2'd0));  // first fanfare note
    send_req(mk(OP_TICK,   32'd1005, 1'b1, 2'd3));  // too early
    send_req(mk(OP_TICK,   32'd1210, 1'b1, 2'd0));  // rest
    send_req(mk(OP_TICK,   32'd1250, 1'b1, 2'd0));
    send_req(mk(OP_TICK,   32'd1260, 1'b0, 2'd0));  // disabled while sounding
    send_req(mk(OP_TICK,   32'd1261, 1'b0, 2'd0));  // disabled while quiet
    send_req(mk(OP_TICK,   32'd1460, 1'b1, 2'd0));
    send_req(mk(OP_TICK,   32'd700,  1'b1, 2'd0));  // time went backwards
    send_req(mk(OP_SELECT, 32'h7FFF_FFF0, 1'b1, 2'd2));
    send_req(mk(OP_TICK,   32'h8000_0005, 1'b1, 2'd1));  // wrapped: signed-behind
    send_req(mk(OP_TICK,   32'h7FFF_FFF0, 1'b1, 2'd1));
    send_req(mk(OP_TICK,   32'h7FFF_FFFF, 1'b1, 2'd1));
    send_req(mk(OP_SELECT, 32'h8000_0000, 1'b0, 2'd3));
    send_req(mk(OP_TICK,   32'h8000_0000, 1'b1, 2'd0));
    send_req(mk(OP_SELECT, 32'hFFFF_FFFF, 1'b1, 2'd0));  // stop while sounding
    send_req(mk(OP_TICK,   32'hFFFF_FFFF, 1'b1, 2'd3));
    send_req(mk(OP_SELECT, 32'd0,    1'b1, 2'd1));
    send_req(mk(OP_TICK,   32'd0,    1'b1, 2'd0));
    send_req(mk(OP_TICK,   32'd210,  1'b1, 2'd0));
    send_req(mk(OP_TICK,   32'd250,  1'b1, 2'd0));
    ms_now = 32'd250;

    for (p = 0; p < 8; p++) begin
      settle();
      case (p)
        0:       begin snd = 1'b1; gp = 7'd0;   end
        1:       begin snd = 1'b1; gp = 7'd127; end
        2:       begin snd = 1'b0; gp = 7'd40;  end
        4:       begin snd = 1'b0; gp = 7'd127; end
        5:       begin snd = 1'b1; gp = 7'd40;  end
        6:       begin snd = 1'b1; gp = 7'd0;   end
        default: begin snd = 1'b1; gp = 7'($urandom); end
      endcase
      apb_write(REG_SOUND_ON, {31'($urandom), snd});
      apb_write(REG_GAP_TICKS, {25'($urandom), gp});
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 57; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 28; stall_pct = 28; end
      endcase
      start = n_sent;
      while (n_sent - start < 110) begin
        calm = ($urandom_range(4) == 0);
        if ($urandom_range(4) == 0) noise_burst();
        else melody_run();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    settle();
    repeat (3) @(posedge clk);
    $display("%0d requests over 8 register settings and 4 pacing modes", n_sent);
    $display("%0d notes sounded, %0d failures, %0d results missing", notes_heard,
             fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout at %0t", $time);
    $display("simulation failed");
    $finish;
  end

endmodule
